// ===== rtl/core/pul_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pul_pkg
// types, constants and fixed-point helpers for the pixel undistort lift
// ----------------------------------------------------------------------------
package pul_pkg;

    localparam int REFINE_PASSES_DEF = 8;
    localparam int FRAC_BITS         = 28;
    localparam int LIFT_SHIFT        = 12;

    typedef logic signed [31:0] q_t;

    typedef enum logic [2:0] {
        REG_INV_FOCAL_X = 3'd0,
        REG_OFFSET_X    = 3'd1,
        REG_INV_FOCAL_Y = 3'd2,
        REG_OFFSET_Y    = 3'd3,
        REG_RADIAL_K1   = 3'd4,
        REG_RADIAL_K2   = 3'd5,
        REG_TANG_P1     = 3'd6,
        REG_TANG_P2     = 3'd7
    } pul_reg_t;

    typedef struct packed {
        logic [15:0] pixel_u;
        logic [15:0] pixel_v;
    } pul_in_t;

    typedef struct packed {
        logic signed [31:0] ray_x;
        logic signed [31:0] ray_y;
        logic               saturated;
    } pul_out_t;

    // point travelling from one refinement pass to the next
    typedef struct packed {
        logic valid;
        q_t   x;
        q_t   y;
        q_t   xd;
        q_t   yd;
        logic flag;
    } pul_pt_t;

    typedef struct packed {
        q_t k1;
        q_t k2;
        q_t p1;
        q_t p2;
    } pul_coef_t;

    typedef struct packed {
        logic sat;
        q_t   val;
    } pul_sat_t;

    function automatic pul_sat_t sat_q(input logic signed [47:0] v);
        pul_sat_t r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (v < -48'sh0000_8000_0000) begin
            r.sat = 1'b1;
            r.val = -32'sh8000_0000;
        end
        else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // q3.28 product, rounded half up
    function automatic pul_sat_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = a * b;
        s = (p + 64'sd134217728) >>> FRAC_BITS;
        return sat_q(s[47:0]);
    endfunction

    function automatic logic signed [47:0] ext(input q_t a);
        return 48'(a);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pixel_undistort_lift.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted input is registered by the lift stage, then runs through REFINE_PASSES passes in turn
// throughput: one transaction per cycle while the output is not stalled; each pass is seven register stages
// a stalled output freezes the whole pipeline through one common enable
// reset clears all valid bits and the configuration registers to zero
// ----------------------------------------------------------------------------
// pixel_undistort_lift
// lifts a pixel to the normalized plane and removes radial/tangential distortion
// ----------------------------------------------------------------------------
module pixel_undistort_lift
    import pul_pkg::*;
#(
    parameter int REFINE_PASSES = REFINE_PASSES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pul_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pul_out_t         out_data
);

    logic [31:0] inv_fx_reg, inv_fy_reg;
    q_t          off_x_reg, off_y_reg;
    pul_coef_t   coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_fx_reg <= '0;
            inv_fy_reg <= '0;
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            coef_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (pul_reg_t'(cfg_index))
                REG_INV_FOCAL_X: inv_fx_reg  <= cfg_data;
                REG_OFFSET_X:    off_x_reg   <= cfg_data;
                REG_INV_FOCAL_Y: inv_fy_reg  <= cfg_data;
                REG_OFFSET_Y:    off_y_reg   <= cfg_data;
                REG_RADIAL_K1:   coef_reg.k1 <= cfg_data;
                REG_RADIAL_K2:   coef_reg.k2 <= cfg_data;
                REG_TANG_P1:     coef_reg.p1 <= cfg_data;
                REG_TANG_P2:     coef_reg.p2 <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // lift stage
    logic [47:0]        px_prod, py_prod;
    logic [35:0]        px_rnd, py_rnd;
    pul_sat_t           lx, ly;
    logic               lift_v_reg, lift_f_reg;
    q_t                 lift_x_reg, lift_y_reg;

    always_comb
    begin
        px_prod = 48'(in_data.pixel_u) * 48'(inv_fx_reg);
        py_prod = 48'(in_data.pixel_v) * 48'(inv_fy_reg);
        px_rnd  = 36'((px_prod + 48'd2048) >> LIFT_SHIFT);
        py_rnd  = 36'((py_prod + 48'd2048) >> LIFT_SHIFT);
        lx      = sat_q($signed({12'd0, px_rnd}) + ext(off_x_reg));
        ly      = sat_q($signed({12'd0, py_rnd}) + ext(off_y_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lift_v_reg <= 1'b0;
        else if (en)
            lift_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lift_x_reg <= lx.val;
            lift_y_reg <= ly.val;
            lift_f_reg <= lx.sat | ly.sat;
        end
    end

    pul_pt_t pt [REFINE_PASSES+1];
    // refinement starts at the distorted point
    assign pt[0] = '{valid: lift_v_reg, x: lift_x_reg, y: lift_y_reg, xd: lift_x_reg,
                     yd: lift_y_reg, flag: lift_f_reg};

    for (genvar i = 0; i < REFINE_PASSES; i++)
    begin : g_pass
        pul_pass u_pass (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .coef  (coef_reg),
            .pin   (pt[i]),
            .pout  (pt[i+1])
        );
    end

    assign out_valid          = pt[REFINE_PASSES].valid;
    assign out_data.ray_x     = pt[REFINE_PASSES].x;
    assign out_data.ray_y     = pt[REFINE_PASSES].y;
    assign out_data.saturated = pt[REFINE_PASSES].flag;

    // backpressure only comes from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall without a pending result");

    a_lift_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> lift_v_reg)
        else $error("accepted transaction lost at lift stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> $stable({lift_v_reg, lift_x_reg, lift_y_reg, lift_f_reg}))
        else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

// ===== rtl/core/pul_pass.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pul_pass
// one refinement pass x = xd - D(x), seven register stages
// ----------------------------------------------------------------------------
module pul_pass
    import pul_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire pul_coef_t coef,
    input  wire pul_pt_t   pin,
    output pul_pt_t        pout
);

    // stage 1: squares and cross product
    logic v1_reg, f1_reg;
    q_t   x1_reg, y1_reg, xd1_reg, yd1_reg, xx1_reg, yy1_reg, xy1_reg;
    // stage 2: r2 and tangential sums
    logic v2_reg, f2_reg;
    q_t   x2_reg, y2_reg, xd2_reg, yd2_reg, xy2_reg, r2_reg, tx2_reg, ty2_reg;
    // stage 3: r2 squared and coefficient products
    logic v3_reg, f3_reg;
    q_t   x3_reg, y3_reg, xd3_reg, yd3_reg, rr3_reg, a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    // stage 4: k2 term
    logic v4_reg, f4_reg;
    q_t   x4_reg, y4_reg, xd4_reg, yd4_reg, kk4_reg, a4_reg, b4_reg, c4_reg, d4_reg, e4_reg;
    // stage 5: radial factor
    logic v5_reg, f5_reg;
    q_t   x5_reg, y5_reg, xd5_reg, yd5_reg, rad5_reg, b5_reg, c5_reg, d5_reg, e5_reg;
    // stage 6: radial displacement
    logic v6_reg, f6_reg;
    q_t   xd6_reg, yd6_reg, mx6_reg, my6_reg, b6_reg, c6_reg, d6_reg, e6_reg;
    // stage 7: update
    logic v7_reg, f7_reg;
    q_t   x7_reg, y7_reg, xd7_reg, yd7_reg;

    pul_sat_t s1_xx, s1_yy, s1_xy;
    pul_sat_t s2_r2, s2_tx, s2_ty;
    pul_sat_t s3_rr, s3_a, s3_b, s3_c, s3_d, s3_e;
    pul_sat_t s4_kk, s5_rad, s6_mx, s6_my;
    pul_sat_t s7_dx, s7_dy, s7_x, s7_y;

    always_comb
    begin
        s1_xx  = qmul(pin.x, pin.x);
        s1_yy  = qmul(pin.y, pin.y);
        s1_xy  = qmul(pin.x, pin.y);
        s2_r2  = sat_q(ext(xx1_reg) + ext(yy1_reg));
        s2_tx  = sat_q(ext(s2_r2.val) + (ext(xx1_reg) <<< 1));
        s2_ty  = sat_q(ext(s2_r2.val) + (ext(yy1_reg) <<< 1));
        s3_rr  = qmul(r2_reg, r2_reg);
        s3_a   = qmul(coef.k1, r2_reg);
        s3_b   = qmul(coef.p1, xy2_reg);
        s3_c   = qmul(coef.p2, tx2_reg);
        s3_d   = qmul(coef.p2, xy2_reg);
        s3_e   = qmul(coef.p1, ty2_reg);
        s4_kk  = qmul(coef.k2, rr3_reg);
        s5_rad = sat_q(ext(a4_reg) + ext(kk4_reg));
        s6_mx  = qmul(x5_reg, rad5_reg);
        s6_my  = qmul(y5_reg, rad5_reg);
        s7_dx  = sat_q(ext(mx6_reg) + (ext(b6_reg) <<< 1) + ext(c6_reg));
        s7_dy  = sat_q(ext(my6_reg) + (ext(d6_reg) <<< 1) + ext(e6_reg));
        s7_x   = sat_q(ext(xd6_reg) - ext(s7_dx.val));
        s7_y   = sat_q(ext(yd6_reg) - ext(s7_dy.val));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pin.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= pin.x;
            y1_reg  <= pin.y;
            xd1_reg <= pin.xd;
            yd1_reg <= pin.yd;
            xx1_reg <= s1_xx.val;
            yy1_reg <= s1_yy.val;
            xy1_reg <= s1_xy.val;
            f1_reg  <= pin.flag | s1_xx.sat | s1_yy.sat | s1_xy.sat;

            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            xd2_reg <= xd1_reg;
            yd2_reg <= yd1_reg;
            xy2_reg <= xy1_reg;
            r2_reg  <= s2_r2.val;
            tx2_reg <= s2_tx.val;
            ty2_reg <= s2_ty.val;
            f2_reg  <= f1_reg | s2_r2.sat | s2_tx.sat | s2_ty.sat;

            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            xd3_reg <= xd2_reg;
            yd3_reg <= yd2_reg;
            rr3_reg <= s3_rr.val;
            a3_reg  <= s3_a.val;
            b3_reg  <= s3_b.val;
            c3_reg  <= s3_c.val;
            d3_reg  <= s3_d.val;
            e3_reg  <= s3_e.val;
            f3_reg  <= f2_reg | s3_rr.sat | s3_a.sat | s3_b.sat | s3_c.sat
                       | s3_d.sat | s3_e.sat;

            x4_reg  <= x3_reg;
            y4_reg  <= y3_reg;
            xd4_reg <= xd3_reg;
            yd4_reg <= yd3_reg;
            kk4_reg <= s4_kk.val;
            a4_reg  <= a3_reg;
            b4_reg  <= b3_reg;
            c4_reg  <= c3_reg;
            d4_reg  <= d3_reg;
            e4_reg  <= e3_reg;
            f4_reg  <= f3_reg | s4_kk.sat;

            x5_reg   <= x4_reg;
            y5_reg   <= y4_reg;
            xd5_reg  <= xd4_reg;
            yd5_reg  <= yd4_reg;
            rad5_reg <= s5_rad.val;
            b5_reg   <= b4_reg;
            c5_reg   <= c4_reg;
            d5_reg   <= d4_reg;
            e5_reg   <= e4_reg;
            f5_reg   <= f4_reg | s5_rad.sat;

            xd6_reg <= xd5_reg;
            yd6_reg <= yd5_reg;
            mx6_reg <= s6_mx.val;
            my6_reg <= s6_my.val;
            b6_reg  <= b5_reg;
            c6_reg  <= c5_reg;
            d6_reg  <= d5_reg;
            e6_reg  <= e5_reg;
            f6_reg  <= f5_reg | s6_mx.sat | s6_my.sat;

            x7_reg  <= s7_x.val;
            y7_reg  <= s7_y.val;
            xd7_reg <= xd6_reg;
            yd7_reg <= yd6_reg;
            f7_reg  <= f6_reg | s7_dx.sat | s7_dy.sat | s7_x.sat | s7_y.sat;
        end
    end

    assign pout = '{valid: v7_reg, x: x7_reg, y: y7_reg, xd: xd7_reg, yd: yd7_reg,
                    flag: f7_reg};

endmodule
`default_nettype wire

// ===== tb/pixel_undistort_lift_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_undistort_lift_tb
// drives pixel coordinates through several lens settings and checks every
// lifted, undistorted ray against a fixed-point prediction in the bench
// ----------------------------------------------------------------------------
module pixel_undistort_lift_tb;
    import pul_pkg::*;

    localparam int PASSES    = 8;
    localparam int LATENCY   = 1 + 7 * PASSES;
    localparam int WDOG_MAX  = 20000;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic     in_valid;
    logic     in_stall;
    pul_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    pul_out_t out_data;

    pul_in_t  pending_px[$];
    pul_out_t expected_rays[$];

    // lens configuration as seen by the predictor
    logic [31:0] lens_ifx, lens_ify;
    q_t lens_ox, lens_oy, lens_k1, lens_k2, lens_p1, lens_p2;

    bit     failed;
    bit     stim_done;
    bit     idle_en;
    bit     hold_req;
    bit     in_acc;
    int     hold_left;
    int     quiet_cycles;

    pixel_undistort_lift #(.REFINE_PASSES(PASSES)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- predictor ----------------
    bit clamp_hit;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            clamp_hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clamp_hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< 27);
        return clamp32(p >>> 28);
    endfunction

    function automatic longint lift_axis(input logic [15:0] pix, input logic [31:0] ifoc,
                                         input q_t off);
        longint unsigned p;
        p = (64'(pix) * 64'(ifoc) + 64'd2048) >> 12;
        return clamp32(longint'(p) + longint'(off));
    endfunction

    function automatic pul_out_t undistort_ray(input pul_in_t px);
        pul_out_t r;
        longint xd, yd, x, y, x2, y2, xy, r2, rad, tx, ty, dx, dy;
        clamp_hit = 1'b0;
        xd = lift_axis(px.pixel_u, lens_ifx, lens_ox);
        yd = lift_axis(px.pixel_v, lens_ify, lens_oy);
        x = xd;
        y = yd;
        for (int i = 0; i < PASSES; i++)
        begin
            x2 = fmul(x, x);
            y2 = fmul(y, y);
            xy = fmul(x, y);
            r2 = clamp32(x2 + y2);
            rad = clamp32(fmul(lens_k1, r2) + fmul(lens_k2, fmul(r2, r2)));
            tx = clamp32(r2 + 2 * x2);
            ty = clamp32(r2 + 2 * y2);
            dx = clamp32(fmul(x, rad) + 2 * fmul(lens_p1, xy) + fmul(lens_p2, tx));
            dy = clamp32(fmul(y, rad) + 2 * fmul(lens_p2, xy) + fmul(lens_p1, ty));
            x = clamp32(xd - dx);
            y = clamp32(yd - dy);
        end
        r.ray_x = x[31:0];
        r.ray_y = y[31:0];
        r.saturated = clamp_hit;
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // move on only when the offered transaction was taken at the last rising edge
            if (!in_valid || in_acc)
            begin
                if (pending_px.size() > 0 && (!idle_en || $urandom_range(99) >= 37))
                begin
                    in_data  <= pending_px.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // predict on acceptance, at the rising edge
    always @(posedge clk)
    begin
        in_acc <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_rays.push_back(undistort_ray(in_data));
    end

    // receiver stall, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  <= 1'b0;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_en && ($urandom_range(99) < 37);
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        pul_out_t exp_ray;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rays.size() == 0)
            begin
                $display("%0t: unexpected transaction %h", $time, out_data);
                failed = 1'b1;
            end
            else
            begin
                exp_ray = expected_rays.pop_front();
                if (out_data.ray_x !== exp_ray.ray_x)
                begin
                    $display("%0t: ray_x expected %h actual %h", $time,
                             exp_ray.ray_x, out_data.ray_x);
                    failed = 1'b1;
                end
                if (out_data.ray_y !== exp_ray.ray_y)
                begin
                    $display("%0t: ray_y expected %h actual %h", $time,
                             exp_ray.ray_y, out_data.ray_y);
                    failed = 1'b1;
                end
                if (out_data.saturated !== exp_ray.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_ray.saturated, out_data.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side while work is pending
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || stim_done
            || !rst_n || (pending_px.size() == 0 && expected_rays.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input pul_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_INV_FOCAL_X: lens_ifx = val;
            REG_OFFSET_X:    lens_ox  = val;
            REG_INV_FOCAL_Y: lens_ify = val;
            REG_OFFSET_Y:    lens_oy  = val;
            REG_RADIAL_K1:   lens_k1  = val;
            REG_RADIAL_K2:   lens_k2  = val;
            REG_TANG_P1:     lens_p1  = val;
            default:         lens_p2  = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_lens(input logic [31:0] ifx, ox, ify, oy, k1, k2, p1, p2);
        write_reg(REG_INV_FOCAL_X, ifx);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_INV_FOCAL_Y, ify);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_RADIAL_K1, k1);
        write_reg(REG_RADIAL_K2, k2);
        write_reg(REG_TANG_P1, p1);
        write_reg(REG_TANG_P2, p2);
    endtask

    task automatic drain();
        wait (pending_px.size() == 0 && !in_valid && expected_rays.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_px(input logic [15:0] u, input logic [15:0] v);
        pul_in_t p;
        p.pixel_u = u;
        p.pixel_v = v;
        pending_px.push_back(p);
    endtask

    task automatic random_px(input int n, input bit wide);
        for (int i = 0; i < n; i++)
        begin
            if (wide || $urandom_range(9) == 0)
                add_px(16'($urandom), 16'($urandom));
            else
                add_px(16'($urandom_range(10240)), 16'($urandom_range(7680)));
        end
    endtask

    // realistic lens: fx about 500000 px, image 640x480, Q12.4 pixels
    task automatic realistic_lens();
        set_lens(32'd137439 + $urandom_range(40000) - 20000,
                 -32'sd171798692 + $urandom_range(4000000) - 2000000,
                 32'd137439 + $urandom_range(40000) - 20000,
                 -32'sd128849019 + $urandom_range(4000000) - 2000000,
                 $urandom_range(60000000) - 30000000,
                 $urandom_range(20000000) - 10000000,
                 $urandom_range(400000) - 200000,
                 $urandom_range(400000) - 200000);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        hold_left = 0;
        failed = 1'b0;
        stim_done = 1'b0;
        quiet_cycles = 0;
        {lens_ifx, lens_ify, lens_ox, lens_oy} = '0;
        {lens_k1, lens_k2, lens_p1, lens_p2} = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: everything maps to zero
        add_px(16'h0000, 16'hFFFF);
        add_px(16'hFFFF, 16'h0000);
        drain();

        // directed: zero distortion, field extremes and all-ones bits
        set_lens(32'd137439, -32'sd171798692, 32'd137439, -32'sd128849019, 0, 0, 0, 0);
        add_px(16'h0000, 16'h0000);
        add_px(16'hFFFF, 16'hFFFF);
        add_px(16'h5555, 16'hAAAA);
        add_px(16'h1400, 16'h0F00);
        drain();

        // maximum scale and extreme offsets: lift overflow, clamp with zero coefficients
        set_lens(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
        add_px(16'hFFFF, 16'hFFFF);
        add_px(16'h0000, 16'h0000);
        add_px(16'h0001, 16'hFFFF);
        drain();

        // extreme coefficients: products and sums clamp
        set_lens(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_px(16'hFFFF, 16'h0000);
        add_px(16'h8000, 16'h1234);
        add_px(16'h0000, 16'hFFFF);
        drain();
        set_lens(32'd200000, 32'h8000_0000, 32'd200000, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_px(16'h0000, 16'h0000);
        add_px(16'hFFFF, 16'hFFFF);
        add_px(16'h2000, 16'h4000);
        drain();

        // random phases over several realistic lenses
        for (int ph = 0; ph < 4; ph++)
        begin
            realistic_lens();
            random_px(90, 1'b0);
            if (ph == 1)
            begin
                // long receiver hold-off while the sender keeps offering
                wait (in_valid);
                hold_req = 1'b1;
            end
            if (ph == 2)
                idle_en = 1'b0;
            drain();
            idle_en = 1'b1;
        end

        // fully random configuration and pixels
        for (int ph = 0; ph < 2; ph++)
        begin
            set_lens($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
            random_px(60, 1'b1);
            drain();
        end

        stim_done = 1'b1;
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pul_pkg.sv
rtl/core/pul_pass.sv
rtl/core/pixel_undistort_lift.sv
tb/pixel_undistort_lift_tb.sv
